/* src/ssmd_pkg.sv */
// Shared types and constants for the signed subtract/multiply/divide unit.
package ssmd_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_SUB  = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_DIV_ZERO = 1'b1
  } status_t;

  // Control that travels with each data stage.
  typedef struct packed {
    logic valid;
    op_t  op;
    logic neg;   // quotient must be negated
    logic dz;    // divide by zero
  } ctrl_t;

endpackage

/* src/ssmd_if.sv */
// Valid/ready channel interfaces for requests and responses.
interface ssmd_req_if #(
  parameter int unsigned DATA_WIDTH = ssmd_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface ssmd_rsp_if #(
  parameter int unsigned DATA_WIDTH = ssmd_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

/* src/ssmd_prep.sv */
// Entry stage: decode, operand magnitudes, subtraction.
module ssmd_prep #(
  parameter int unsigned DATA_WIDTH = ssmd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid,
  input  logic [1:0]            req_type,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  output ssmd_pkg::ctrl_t       ctrl,
  output logic [DATA_WIDTH-1:0] x,
  output logic [DATA_WIDTH-1:0] y,
  output logic [DATA_WIDTH-1:0] acc
);
  logic                  sa, sb;
  logic [DATA_WIDTH-1:0] ma, mb;
  ssmd_pkg::op_t         op;

  assign op = ssmd_pkg::op_t'(req_type);
  assign sa = operand_a[DATA_WIDTH-1];
  assign sb = operand_b[DATA_WIDTH-1];
  assign ma = sa ? (~operand_a + 1'b1) : operand_a;
  assign mb = sb ? (~operand_b + 1'b1) : operand_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= valid;
    end
    if (en) begin
      ctrl.op  <= op;
      ctrl.neg <= sa ^ sb;
      ctrl.dz  <= (op == ssmd_pkg::OP_DIV) && (operand_b == '0);
      case (op)
        ssmd_pkg::OP_SUB: begin
          x   <= operand_a;
          y   <= operand_b;
          acc <= operand_a - operand_b;
        end
        ssmd_pkg::OP_MUL: begin
          x   <= operand_a;
          y   <= operand_b;
          acc <= '0;
        end
        default: begin
          x   <= ma;
          y   <= mb;
          acc <= '0;
        end
      endcase
    end
  end
endmodule

/* src/ssmd_step.sv */
// One radix-2 step: shift-add multiply bit or restoring divide bit.
module ssmd_step #(
  parameter int unsigned DATA_WIDTH = ssmd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ssmd_pkg::ctrl_t       ctrl_i,
  input  logic [DATA_WIDTH-1:0] x_i,
  input  logic [DATA_WIDTH-1:0] y_i,
  input  logic [DATA_WIDTH-1:0] acc_i,
  output ssmd_pkg::ctrl_t       ctrl_o,
  output logic [DATA_WIDTH-1:0] x_o,
  output logic [DATA_WIDTH-1:0] y_o,
  output logic [DATA_WIDTH-1:0] acc_o
);
  logic [DATA_WIDTH-1:0] r2;
  logic                  ge;

  // partial remainder never exceeds 2*divisor-1, so it fits the word
  assign r2 = {acc_i[DATA_WIDTH-2:0], x_i[DATA_WIDTH-1]};
  assign ge = (r2 >= y_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o.valid <= ctrl_i.valid;
    end
    if (en) begin
      ctrl_o.op  <= ctrl_i.op;
      ctrl_o.neg <= ctrl_i.neg;
      ctrl_o.dz  <= ctrl_i.dz;
      case (ctrl_i.op)
        ssmd_pkg::OP_MUL: begin
          acc_o <= y_i[0] ? (acc_i + x_i) : acc_i;
          x_o   <= {x_i[DATA_WIDTH-2:0], 1'b0};
          y_o   <= {1'b0, y_i[DATA_WIDTH-1:1]};
        end
        ssmd_pkg::OP_DIV: begin
          acc_o <= ge ? (r2 - y_i) : r2;
          x_o   <= {x_i[DATA_WIDTH-2:0], ge};
          y_o   <= y_i;
        end
        default: begin
          acc_o <= acc_i;
          x_o   <= x_i;
          y_o   <= y_i;
        end
      endcase
    end
  end
endmodule

/* src/ssmd_post.sv */
// Exit stage: quotient sign fix, result select, output register.
module ssmd_post #(
  parameter int unsigned DATA_WIDTH = ssmd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ssmd_pkg::ctrl_t       ctrl,
  input  logic [DATA_WIDTH-1:0] x,
  input  logic [DATA_WIDTH-1:0] acc,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] result_value,
  output logic                  status
);
  logic [DATA_WIDTH-1:0] res_next;
  logic                  status_next;

  always_comb begin
    res_next    = '0;
    status_next = ssmd_pkg::ST_OK;
    case (ctrl.op)
      ssmd_pkg::OP_SUB,
      ssmd_pkg::OP_MUL: res_next = acc;
      ssmd_pkg::OP_DIV: begin
        if (ctrl.dz) begin
          status_next = ssmd_pkg::ST_DIV_ZERO;
        end else begin
          res_next = ctrl.neg ? (~x + 1'b1) : x;
        end
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value <= res_next;
      status       <= status_next;
    end
  end
endmodule

/* src/signed_sub_mul_div_unit.sv */
// Signed subtract / multiply / divide unit, DATA_WIDTH-deep radix-2 pipeline.
//
// Each request transaction carries req_type (0 subtract, 1 multiply, 2 divide
// truncating toward zero) and two signed DATA_WIDTH-bit operands; each yields
// one response transaction with result_value wrapped to DATA_WIDTH bits and
// status (1 only on divide by zero, where result_value is 0; code 3 gives 0).
// The product keeps its low bits; the most negative value divided by -1 gives
// the most negative value. The pipeline is one entry stage that forms magnitudes
// and the difference, one pipeline stage per operand bit that retires one
// multiplier bit (shift-add) or one quotient bit (restoring compare-subtract),
// and one exit stage that fixes the quotient sign and holds the result. A new
// request may enter every cycle while the output is not stalled. The whole
// pipeline advances when the output register is empty or being drained, so
// back-pressure stalls every stage together and nothing is lost or repeated.
module signed_sub_mul_div_unit #(
  parameter int unsigned DATA_WIDTH = ssmd_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ssmd_req_if.sink   req,
  ssmd_rsp_if.source rsp
);
  logic en;

  // stage bundles: index 0 is the entry stage, DATA_WIDTH the last step
  ssmd_pkg::ctrl_t       ctrl [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] x    [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] y    [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] acc  [DATA_WIDTH+1];

  // single global advance: the output register is free or being taken
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  ssmd_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (req.valid),
    .req_type  (req.req_type),
    .operand_a (req.operand_a),
    .operand_b (req.operand_b),
    .ctrl      (ctrl[0]),
    .x         (x[0]),
    .y         (y[0]),
    .acc       (acc[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    ssmd_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctrl_i (ctrl[i]),
      .x_i    (x[i]),
      .y_i    (y[i]),
      .acc_i  (acc[i]),
      .ctrl_o (ctrl[i+1]),
      .x_o    (x[i+1]),
      .y_o    (y[i+1]),
      .acc_o  (acc[i+1])
    );
  end

  // y of the last step is not needed by the exit stage
  logic unused_y;
  assign unused_y = ^y[DATA_WIDTH];

  ssmd_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .ctrl         (ctrl[DATA_WIDTH]),
    .x            (x[DATA_WIDTH]),
    .acc          (acc[DATA_WIDTH]),
    .valid        (rsp.valid),
    .result_value (rsp.result_value),
    .status       (rsp.status)
  );
endmodule

/* sim/ssmd_checker.sv */
`timescale 1ns / 1ps
// Checker: watches request and response channels, predicts and compares results.
module ssmd_checker #(
  parameter int unsigned DATA_WIDTH = ssmd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  logic [1:0]            req_type,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  logic [DATA_WIDTH-1:0] result_value,
  input  logic                  status,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  st;
  } answer_t;

  answer_t answers_due[$];

  function automatic answer_t compute_answer(logic [1:0] op, logic [DATA_WIDTH-1:0] a,
                                             logic [DATA_WIDTH-1:0] b);
    answer_t r;
    logic [DATA_WIDTH-1:0] ma, mb, q;
    logic [2*DATA_WIDTH-1:0] p;
    r.value = '0;
    r.st = ssmd_pkg::ST_OK;
    case (op)
      ssmd_pkg::OP_SUB: r.value = a - b;
      ssmd_pkg::OP_MUL: begin
        p = a * b;
        r.value = p[DATA_WIDTH-1:0];
      end
      ssmd_pkg::OP_DIV: begin
        if (b == '0) begin
          r.st = ssmd_pkg::ST_DIV_ZERO;
        end else begin
          ma = a[DATA_WIDTH-1] ? -a : a;
          mb = b[DATA_WIDTH-1] ? -b : b;
          q = ma / mb;
          r.value = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? -q : q;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = answers_due.size();

  always @(posedge clk) begin
    answer_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (req_valid && req_ready)
        answers_due.push_back(compute_answer(req_type, operand_a, operand_b));
      if (rsp_valid && rsp_ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected response transaction: result_value %0h", result_value);
          errs++;
        end else begin
          want = answers_due.pop_front();
          if (want.value !== result_value) begin
            $error("result_value expected %0h actual %0h", want.value, result_value);
            errs++;
          end
          if (want.st !== status) begin
            $error("status expected %0b actual %0b", want.st, status);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* sim/signed_sub_mul_div_unit_test.sv */
`timescale 1ns / 1ps
// Testbench top: drives stimulus into the unit and reports the verdict.
module signed_sub_mul_div_unit_test;

  localparam int unsigned W = ssmd_pkg::DATA_WIDTH_DEF;
  localparam int LATENCY = W + 2;
  localparam int RANDOM_ITEMS = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   calm = 1'b0;      // last part of the run: no idling
  bit   hold_rsp = 1'b0;  // long receiver hold-off request
  bit   stim_done = 1'b0;

  ssmd_req_if #(.DATA_WIDTH(W)) req ();
  ssmd_rsp_if #(.DATA_WIDTH(W)) rsp ();

  signed_sub_mul_div_unit #(.DATA_WIDTH(W)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  ssmd_checker #(.DATA_WIDTH(W)) checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
    .operand_a(req.operand_a), .operand_b(req.operand_b),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .result_value(rsp.result_value), .status(rsp.status),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Inputs known from time zero.
  initial begin
    req.valid = 1'b0;
    req.req_type = ssmd_pkg::OP_SUB;
    req.operand_a = '0;
    req.operand_b = '0;
    rsp.ready = 1'b0;
  end

  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MINUS1  = '1;

  // Operand picker: corners mixed with small and fully random values.
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = MAX_POS;
      1: v = MAX_NEG;
      2: v = MINUS1;
      3: v = $urandom_range(0, 3);
      4: v = -$urandom_range(0, 300);
      5: v = $urandom_range(0, 300);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // One request transaction; valid stays high across back-to-back items.
  task automatic send_item(logic [1:0] op, logic [W-1:0] a, logic [W-1:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (3 * LATENCY) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        stall = $urandom_range(1, 6);
        repeat (stall) @(negedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [W-1:0] a, b;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: overflow, min / -1, divide by zero, unused code.
    send_item(ssmd_pkg::OP_SUB, MAX_NEG, 1);
    send_item(ssmd_pkg::OP_SUB, MAX_POS, MINUS1);
    send_item(ssmd_pkg::OP_SUB, 0, MAX_NEG);
    send_item(ssmd_pkg::OP_MUL, MAX_POS, MAX_POS);
    send_item(ssmd_pkg::OP_MUL, MAX_NEG, MINUS1);
    send_item(ssmd_pkg::OP_MUL, MINUS1, MINUS1);
    send_item(ssmd_pkg::OP_MUL, '1, 0);
    send_item(ssmd_pkg::OP_DIV, MAX_NEG, MINUS1);
    send_item(ssmd_pkg::OP_DIV, 7, 0);
    send_item(ssmd_pkg::OP_DIV, 0, 0);
    send_item(ssmd_pkg::OP_DIV, -7, 2);
    send_item(ssmd_pkg::OP_DIV, 7, -2);
    send_item(ssmd_pkg::OP_DIV, -7, -2);
    send_item(ssmd_pkg::OP_DIV, MAX_POS, MAX_NEG);
    send_item(ssmd_pkg::OP_DIV, MAX_NEG, MAX_NEG);
    send_item(ssmd_pkg::OP_DIV, 3, 5);
    send_item(ssmd_pkg::OP_NONE, '1, '1);
    send_item(ssmd_pkg::OP_NONE, 0, 0);

    // Sender pauses until all results are back.
    drain_wait();

    // Receiver holds off while the sender keeps offering: pipeline fills.
    hold_rsp = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS * 4 / 5) calm = 1'b1;
      a = pick_operand();
      b = pick_operand();
      send_item(2'($urandom_range(0, 3)), a, b);
    end
    drain_wait();
    repeat (LATENCY + 4) @(negedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
